// ----- design/svs_pkg.sv -----
// ----------------------------------------------------------------------------
// svs_pkg: shared types, constants and helpers for the stable vector sort core
// Holds the store depth, the sort-key helpers and the control/status structs.
// ----------------------------------------------------------------------------
package svs_pkg;

  localparam int unsigned MaxLen  = 64;
  localparam int unsigned IdxW    = $clog2(MaxLen);
  localparam int unsigned CntW    = $clog2(MaxLen + 1);
  localparam int unsigned DataW   = 64;

  typedef logic [DataW-1:0] word_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [IdxW-1:0]  idx_t;

  // commands from controller to datapath
  typedef struct packed {
    logic insert;   // insert the incoming value into the cells
    logic drop;     // store full, mark the run truncated
    logic shift_out;// move the cells one place toward the head
    logic clear;    // end of run, reset fill and overflow
  } svs_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    cnt_t fill;
  } svs_stat_t;

  function automatic logic is_nan(input word_t b);
    return (b[62:52] == 11'h7ff) && (b[51:0] != '0);
  endfunction

  // monotonic unsigned key, both zeros map to one key
  function automatic word_t order_key(input word_t b);
    if (b[62:0] == '0) return {1'b1, 63'b0};
    if (b[63]) return ~b;
    return {1'b1, b[62:0]};
  endfunction

  // true when a is placed strictly before b
  function automatic logic goes_before(input word_t a, input word_t b, input logic desc);
    if (is_nan(a)) return 1'b0;
    if (is_nan(b)) return 1'b1;
    if (desc) return order_key(a) > order_key(b);
    return order_key(a) < order_key(b);
  endfunction

endpackage

// ----- design/svs_datapath.sv -----
// ----------------------------------------------------------------------------
// svs_datapath: register cell array for the insertion sort
// Each cell compares the new value against its own entry in parallel; the
// array shifts to open a slot, and drains toward the head on output.
// ----------------------------------------------------------------------------
module svs_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  svs_pkg::svs_cmd_t  cmd,
  input  svs_pkg::word_t   in_value,
  input  logic             descending,
  output svs_pkg::svs_stat_t stat,
  output svs_pkg::word_t   head_value,
  output logic             overflow
);
  import svs_pkg::*;

  word_t cell_r [MaxLen];
  word_t cell_nxt [MaxLen];
  word_t prev_cell [MaxLen];
  word_t next_cell [MaxLen];
  cnt_t  fill_r, fill_nxt;
  logic  ovf_r, ovf_nxt;
  logic [MaxLen-1:0] ahead;
  logic [MaxLen-1:0] ahead_pfx;
  logic [MaxLen-1:0] pfx_prev;

  // per-cell compare: new value precedes this occupied cell
  always_comb begin
    for (int i = 0; i < MaxLen; i++) begin
      ahead[i] = (cnt_t'(i) < fill_r) && goes_before(in_value, cell_r[i], descending);
    end
  end

  // insert slot is the first cell the new value precedes, so mark it and all after
  always_comb begin
    ahead_pfx[0] = ahead[0];
    for (int i = 1; i < MaxLen; i++) ahead_pfx[i] = ahead_pfx[i-1] | ahead[i];
  end

  assign pfx_prev = {ahead_pfx[MaxLen-2:0], 1'b0};

  // neighbor cells for the insert shift and the drain shift
  always_comb begin
    prev_cell[0] = cell_r[0];
    for (int i = 1; i < MaxLen; i++) prev_cell[i] = cell_r[i-1];
    for (int i = 0; i < MaxLen - 1; i++) next_cell[i] = cell_r[i+1];
    next_cell[MaxLen-1] = cell_r[MaxLen-1];
  end

  // cell update: insert with shift, or drain toward the head
  always_comb begin
    for (int i = 0; i < MaxLen; i++) begin
      cell_nxt[i] = cell_r[i];
      if (cmd.insert) begin
        if (cnt_t'(i) <= fill_r) begin
          if (pfx_prev[i]) cell_nxt[i] = prev_cell[i];
          else if (ahead[i] || (cnt_t'(i) == fill_r)) cell_nxt[i] = in_value;
        end
      end else if (cmd.shift_out) begin
        cell_nxt[i] = next_cell[i];
      end
    end
  end

  // fill count and overflow flag
  always_comb begin
    fill_nxt = fill_r;
    ovf_nxt  = ovf_r;
    if (cmd.clear) begin
      fill_nxt = '0;
      ovf_nxt  = 1'b0;
    end else begin
      if (cmd.insert) fill_nxt = fill_r + cnt_t'(1);
      if (cmd.drop)   ovf_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxLen; i++) cell_r[i] <= cell_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign stat.full  = (fill_r == cnt_t'(MaxLen));
  assign stat.fill  = fill_r;
  assign head_value = cell_r[0];
  assign overflow   = ovf_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cnt_t'(MaxLen)) else $error("fill count past capacity");
  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !stat.full) else $error("insert into full store");
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (fill_r == '0) && !ovf_r) else $error("clear did not reset fill");

endmodule

// ----- design/svs_ctrl.sv -----
// ----------------------------------------------------------------------------
// svs_ctrl: sequencer for the sort core
// Collects a run one request a cycle, then drains the sorted cells out.
// ----------------------------------------------------------------------------
module svs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_last,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic               out_last,
  input  svs_pkg::svs_stat_t stat,
  output svs_pkg::svs_cmd_t  cmd
);
  import svs_pkg::*;

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic state_r, state_nxt;
  cnt_t left_r, left_nxt;
  logic in_fire, out_fire;

  assign in_tready  = (state_r == ST_FILL);
  assign out_tvalid = (state_r == ST_DRAIN);
  assign out_last   = (left_r == cnt_t'(1));
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_tvalid && out_tready;

  // commands to the cell array
  always_comb begin
    cmd.insert    = in_fire && !stat.full;
    cmd.drop      = in_fire && stat.full;
    cmd.shift_out = out_fire;
    cmd.clear     = out_fire && out_last;
  end

  // state and remaining count
  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    case (state_r)
      ST_FILL: begin
        if (in_fire && in_last) begin
          state_nxt = ST_DRAIN;
          left_nxt  = stat.full ? stat.fill : stat.fill + cnt_t'(1);
        end
      end
      ST_DRAIN: begin
        if (out_fire) begin
          left_nxt = left_r - cnt_t'(1);
          if (out_last) state_nxt = ST_FILL;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
    end
  end

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (left_r != '0)) else $error("draining with no items");
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("fill and drain at once");
  a_back_to_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (state_r == ST_FILL)) else $error("no return to fill");

endmodule

// ----- design/stable_vector_sort_core.sv -----
// ----------------------------------------------------------------------------
// stable_vector_sort_core: stable insertion sort of one vector of doubles
//
//  channel  dir  payload
//  in_      in   tdata = value[63:0], tlast = last
//  out_     out  tdata = sorted_value[63:0], tlast = end_of_run, tuser = truncated
//  cfg_     in   wdata = descending
//
// One element is inserted per cycle into a 64-cell compare/shift array.
// A run of n stored items drains one result per cycle while out_tready is high,
// through the single shift path of the cell array; input is held off during drain.
// Reset clears the fill count, overflow flag, state and direction register.
// Output stalls simply hold the cell array and the head result.
// ----------------------------------------------------------------------------
module stable_vector_sort_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // value[63:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // sorted_value[63:0]
  output logic        out_tlast,
  output logic        out_tuser,  // truncated
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import svs_pkg::*;

  svs_cmd_t  cmd;
  svs_stat_t stat;
  logic      desc_r;
  logic      ovf;

  // direction register
  always_ff @(posedge clk) begin
    if (!rst_n) desc_r <= 1'b0;
    else if (cfg_we) desc_r <= cfg_wdata;
  end

  svs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_last    (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_last   (out_tlast),
    .stat       (stat),
    .cmd        (cmd)
  );

  svs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_value   (in_tdata),
    .descending (desc_r),
    .stat       (stat),
    .head_value (out_tdata),
    .overflow   (ovf)
  );

  assign out_tuser = ovf;

endmodule
